### rtl/core/cpfm_pkg.sv
`default_nettype none

package cpfm_pkg;

    // Fixed field widths of the ports.
    localparam int CAP_W    = 16;
    localparam int TF_W     = 24;
    localparam int PERIOD_W = 33;
    localparam int FREQ_W   = 32;

    // Fraction bits of the frequency result and the divider word width.
    localparam int Q_FRAC = 8;
    localparam int DIV_W  = TF_W + Q_FRAC;

    localparam logic [TF_W-1:0] TF_RESET = 24'd1000000;

    localparam int COUNTER_BITS_DEF  = 16;
    localparam int OVERFLOW_BITS_DEF = 16;

    // Event codes carried on the action field.
    localparam logic ACT_CAPTURE  = 1'b0;
    localparam logic ACT_OVERFLOW = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_PUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

### rtl/core/cpfm_div.sv
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle.
module cpfm_div
    import cpfm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output t_div_stat             o_stat,
    output logic      [DIV_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_acc;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvs;

    logic [DIV_W:0]   s_shift;
    logic [DIV_W+1:0] s_trial;
    logic             s_ge;
    logic [DIV_W-1:0] n_acc;

    always_comb begin
        s_shift = {r_acc, r_quo[DIV_W-1]};
        s_trial = {1'b0, s_shift} - {2'b00, r_dvs};
        s_ge    = !s_trial[DIV_W+1];
        n_acc   = s_ge ? s_trial[DIV_W-1:0] : s_shift[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_quo <= {r_quo[DIV_W-2:0], s_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

### rtl/core/capture_period_frequency_meter_top.sv
`default_nettype none

// Reciprocal frequency meter fed by timer capture events.
// Input channel (i_in_valid / o_in_stall): one beat is one timer event, either
// a capture with its counter value or a counter overflow. The first capture
// stores the start count and arms the meter; overflows while armed are counted
// and saturate. The second capture produces one output beat.
// Output channel (o_out_valid / i_out_stall): period in ticks (33-bit two's
// complement), frequency timer_freq / period in unsigned Q24.8, and a flag
// that is set when the period is positive.
// Overflow beats and first captures are accepted while the meter is idle. A
// second capture runs in order until its result is registered: the period
// is formed, the divider is set up, the shared subtract-and-compare unit of
// the restoring divider runs (one quotient bit per pass), the done flag is
// passed to the sequencer, and the output is loaded. o_in_stall stays high
// meanwhile, so no new event is taken before the result is loaded. When the
// receiver stalls, the finished result waits inside until the output is free.
// A synchronous active-low reset disarms the meter, clears the overflow count
// and the output valid, and sets timer_freq to 1000000. The user writes it
// through i_cfg_we / i_cfg_wdata only while the meter is idle (unguarded).
module capture_period_frequency_meter_top
    import cpfm_pkg::*;
#(
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
    parameter int OVERFLOW_BITS = OVERFLOW_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [TF_W-1:0]     i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_action,
    input  wire logic [CAP_W-1:0]    i_capture_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic signed [PERIOD_W-1:0] o_period_ticks,
    output logic [FREQ_W-1:0]        o_freq_q8,
    output logic                     o_valid_res
);

    // Full width of the stop count including the counter wraps.
    localparam int PW = COUNTER_BITS + OVERFLOW_BITS;
    // Width large enough for both the period magnitude and a divider word.
    localparam int EW = (PW > DIV_W) ? PW : DIV_W;

    t_state r_state;
    t_state n_state;

    logic [TF_W-1:0]          r_tf;
    logic                     r_armed;
    logic [COUNTER_BITS-1:0]  r_start;
    logic [OVERFLOW_BITS-1:0] r_ovf;
    logic [PW:0]              r_diff;
    logic                     r_pos;
    logic                     r_qok;

    logic                     r_out_valid;
    logic [PERIOD_W-1:0]      r_period_out;
    logic [FREQ_W-1:0]        r_freq_out;
    logic                     r_valid_out;

    logic                     s_in_acc;
    logic                     s_div_start;
    logic                     s_load_out;
    logic [COUNTER_BITS-1:0]  s_cap;
    logic [PW-1:0]            s_stop;
    logic [EW-1:0]            s_mag;
    logic                     s_pos;
    logic                     s_big;
    t_div_stat                s_div_stat;
    logic [DIV_W-1:0]         s_quo;

    assign s_in_acc = i_in_valid && !o_in_stall;
    assign s_cap    = COUNTER_BITS'(i_capture_value);
    assign s_stop   = {r_ovf, s_cap};

    // Period classification: a zero or negative period gives no frequency,
    // and a period beyond the divider word gives a zero quotient.
    assign s_mag = EW'(r_diff[PW-1:0]);
    assign s_pos = !r_diff[PW] && (r_diff != '0);
    assign s_big = s_mag > EW'({DIV_W{1'b1}});

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        s_div_start = 1'b0;
        s_load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && i_action == ACT_CAPTURE && r_armed) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                s_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (s_div_stat.done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    s_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Measurement state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tf    <= TF_RESET;
            r_armed <= 1'b0;
            r_start <= '0;
            r_ovf   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tf <= i_cfg_wdata;
            end
            if (s_in_acc) begin
                if (i_action == ACT_OVERFLOW) begin
                    if (r_armed && r_ovf != {OVERFLOW_BITS{1'b1}}) begin
                        r_ovf <= r_ovf + 1'b1;
                    end
                end else if (!r_armed) begin
                    r_start <= s_cap;
                    r_armed <= 1'b1;
                end else begin
                    r_ovf   <= '0;
                    r_armed <= 1'b0;
                end
            end
        end
    end

    // Period is formed in the accept cycle of the closing capture.
    always_ff @(posedge i_clk) begin
        if (s_in_acc && i_action == ACT_CAPTURE && r_armed) begin
            r_diff <= {1'b0, s_stop} - (PW + 1)'(r_start);
        end
        if (s_div_start) begin
            r_pos <= s_pos;
            r_qok <= s_pos && !s_big;
        end
    end

    cpfm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend ({r_tf, {Q_FRAC{1'b0}}}),
        .i_divisor  (s_mag[DIV_W-1:0]),
        .o_stat     (s_div_stat),
        .o_quotient (s_quo)
    );

    // Output register. The quotient always fits in the result width since the
    // dividend is a single divider word, so no saturation logic is needed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load_out) begin
            r_period_out <= PERIOD_W'($signed(r_diff));
            r_freq_out   <= r_qok ? FREQ_W'(s_quo) : '0;
            r_valid_out  <= r_pos;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_period_ticks = r_period_out;
    assign o_freq_q8      = r_freq_out;
    assign o_valid_res    = r_valid_out;

`ifndef ASSERT_OFF
    a_ovf_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf != '0) |-> r_armed)
        else $error("overflow count is nonzero while the meter is disarmed");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_start |-> !s_div_stat.busy)
        else $error("divider started while still busy");

    a_invalid_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |-> (o_freq_q8 == '0))
        else $error("invalid result carries a nonzero frequency");

    a_valid_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |->
            (!o_period_ticks[PERIOD_W-1] && o_period_ticks != '0))
        else $error("valid result with a period that is not positive");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
`default_nettype none

// Self-checking bench for the capture-based period and frequency meter.
// An initial block builds the timer event stream phase by phase and fills a
// queue of pending events. A clocked driver presents those events on the input
// channel. A clocked monitor takes finished measurements from the output channel.
// Each accepted event runs through a small behavioral model of the meter. That
// model keeps its own armed flag, start count, overflow count and timer
// frequency. It pushes the expected measurement for every second capture.
module tb;
    import cpfm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles the meter may need after its last beat to finish a divide.
    localparam int SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic              action;
        logic [CAP_W-1:0]  cap;
        logic              drain_first;   // hold this beat until all results are in
    } t_tmr_evt;

    typedef struct packed {
        logic signed [PERIOD_W-1:0] period;
        logic [FREQ_W-1:0]          freq;
        logic                       ok;
    } t_meas;

    // Clock, reset and every input of the meter start at a known value.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [TF_W-1:0]   cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_action = ACT_CAPTURE;
    logic [CAP_W-1:0]  in_cap = '0;
    logic              out_stall = 1'b0;

    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [PERIOD_W-1:0] o_period_ticks;
    logic [FREQ_W-1:0]          o_freq_q8;
    logic                       o_valid_res;

    capture_period_frequency_meter_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (in_action),
        .i_capture_value (in_cap),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_period_ticks  (o_period_ticks),
        .o_freq_q8       (o_freq_q8),
        .o_valid_res     (o_valid_res)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Stimulus queue and the queue of measurements that are still owed.
    t_tmr_evt pending_evts[$];
    t_meas    owed_meas[$];

    // Behavioral state of the meter, updated on every accepted input beat.
    logic                         mdl_armed = 1'b0;
    logic [CAP_W-1:0]             mdl_start = '0;
    logic [OVERFLOW_BITS_DEF-1:0] mdl_ovf = '0;
    logic [TF_W-1:0]              mdl_tf = TF_RESET;

    // Phase controls. The initial block changes them with nonblocking writes.
    logic    feeding = 1'b0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    int      mismatches = 0;
    int      evts_taken = 0;
    int      meas_seen = 0;
    int      meas_invalid = 0;
    int      quiet_cycles = 0;
    int      tf_settings = 0;

    // Apply one timer event to the model. A second capture yields a measurement:
    // period = stop + 65536 * overflows - start, kept as 33-bit two's complement.
    // The frequency is the Q24.8 quotient (timer_freq * 256) / period. It is
    // truncated and clamped to 32 bits. A period of zero or below gives no
    // frequency and clears the valid flag.
    task automatic track_timer_evt(input logic act, input logic [CAP_W-1:0] cap);
        logic [PERIOD_W-1:0] stop_total;
        logic [PERIOD_W-1:0] span;
        logic [63:0]         quot;
        t_meas               m;
        if (act == ACT_OVERFLOW) begin
            if (mdl_armed && mdl_ovf != '1) begin
                mdl_ovf = mdl_ovf + 1'b1;
            end
        end else if (!mdl_armed) begin
            mdl_start = cap;
            mdl_armed = 1'b1;
        end else begin
            stop_total = {1'b0, mdl_ovf, cap};
            span = stop_total - {{(PERIOD_W - CAP_W){1'b0}}, mdl_start};
            m.period = span;
            if (stop_total > {{(PERIOD_W - CAP_W){1'b0}}, mdl_start}) begin
                quot = ({40'd0, mdl_tf} << Q_FRAC) / {31'd0, span};
                if (quot > 64'hFFFF_FFFF) begin
                    quot = 64'hFFFF_FFFF;
                end
                m.freq = quot[FREQ_W-1:0];
                m.ok = 1'b1;
            end else begin
                m.freq = '0;
                m.ok = 1'b0;
            end
            owed_meas.push_back(m);
            mdl_ovf = '0;
            mdl_armed = 1'b0;
        end
    endtask

    // Input driver. A beat is accepted at an edge where valid is high and stall
    // is low. The model is updated from the values that were on the pins for
    // that beat. A new beat goes out only when the slot is free. Valid is rolled
    // against the sender idle rate and never looks at stall. A stalled beat
    // stays put.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                track_timer_evt(in_action, in_cap);
                evts_taken++;
            end
            if (!in_valid || !o_in_stall) begin
                if (feeding && pending_evts.size() != 0
                        && !(pending_evts[0].drain_first && owed_meas.size() != 0)
                        && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_action <= pending_evts[0].action;
                    in_cap <= pending_evts[0].cap;
                    void'(pending_evts.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Each accepted measurement is checked field by field
    // against the oldest one owed. The stall for the next cycle is rolled
    // independently of everything else.
    always @(posedge i_clk) begin
        t_meas want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            meas_seen++;
            if (!o_valid_res) begin
                meas_invalid++;
            end
            if (owed_meas.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: unrequested measurement period=%0d freq=%0h valid=%0b",
                             o_period_ticks, o_freq_q8, o_valid_res);
                end
            end else begin
                want = owed_meas.pop_front();
                if (o_period_ticks !== want.period || o_freq_q8 !== want.freq
                        || o_valid_res !== want.ok) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: measurement %0d: period %0d (want %0d) ",
                                 meas_seen, o_period_ticks, want.period,
                                 "freq %0h (want %0h) valid %0b (want %0b)",
                                 o_freq_q8, want.freq, o_valid_res, want.ok);
                    end
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog. It counts cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [CAP_W-1:0] pick_count();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return CAP_W'($urandom());
    endfunction

    task automatic add_evt(input logic act, input logic [CAP_W-1:0] cap,
                           input logic hold = 1'b0);
        t_tmr_evt e;
        e.action = act;
        e.cap = cap;
        e.drain_first = hold;
        pending_evts.push_back(e);
    endtask

    // Random traffic. Most of it is whole measurements: a start capture, a few
    // overflows and a stop capture. The rest is stray overflows and lone
    // captures that shift the start/stop pairing.
    task automatic add_random_traffic(input int count);
        int               n;
        int               k;
        int               r;
        logic [CAP_W-1:0] t0;
        logic [CAP_W-1:0] t1;
        n = 0;
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 5) begin
                add_evt(ACT_OVERFLOW, CAP_W'($urandom()));
                n++;
            end else if (r < 9) begin
                add_evt(ACT_CAPTURE, pick_count());
                n++;
            end else begin
                t0 = pick_count();
                add_evt(ACT_CAPTURE, t0, $urandom_range(49) == 0);
                k = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(2);
                for (int i = 0; i < k; i++) begin
                    add_evt(ACT_OVERFLOW, CAP_W'($urandom()));
                end
                // A stop near the start exercises periods of zero or just either side.
                t1 = ($urandom_range(3) == 0) ? t0 + CAP_W'($urandom_range(4)) - 2'd2
                                             : pick_count();
                add_evt(ACT_CAPTURE, t1);
                n += k + 2;
            end
        end
    endtask

    // Wait until the meter holds nothing of ours, then let it finish any event
    // that yields no result before the register may change.
    task automatic wait_idle();
        while (pending_evts.size() != 0 || in_valid || owed_meas.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timer_freq(input logic [TF_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        mdl_tf = val;
        tf_settings++;
    endtask

    // Run one phase: set the idling rates, release the queued events and wait
    // for every measurement to come back.
    task automatic run_phase(input int idle_pct, input int stall_pct);
        @(posedge i_clk);
        send_idle_pct <= idle_pct;
        recv_stall_pct <= stall_pct;
        feeding <= 1'b1;
        wait_idle();
        feeding <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run with the reset timer frequency and no idling.
        add_evt(ACT_OVERFLOW, '1);                 // overflow while disarmed is dropped
        add_evt(ACT_CAPTURE, '0);
        add_evt(ACT_CAPTURE, '0);                  // zero period, flagged invalid
        add_evt(ACT_CAPTURE, '1);
        add_evt(ACT_CAPTURE, '0);                  // most negative period
        add_evt(ACT_CAPTURE, '0);
        add_evt(ACT_CAPTURE, 16'd1);               // shortest valid period
        add_evt(ACT_CAPTURE, 16'd40000);
        add_evt(ACT_OVERFLOW, 16'h5A5A);
        add_evt(ACT_OVERFLOW, 16'hA5A5);
        add_evt(ACT_CAPTURE, 16'd39999);           // two wraps, stop below start
        add_evt(ACT_CAPTURE, '1);
        add_evt(ACT_OVERFLOW, '0);
        add_evt(ACT_CAPTURE, '0);                  // wrap over to a period of one
        add_evt(ACT_CAPTURE, 16'd1234, 1'b1);      // sender holds until drained
        add_evt(ACT_CAPTURE, 16'd5678);
        add_evt(ACT_CAPTURE, '0);
        add_evt(ACT_OVERFLOW, '0);
        add_evt(ACT_CAPTURE, '0);                  // exactly one full wrap
        run_phase(0, 0);

        // Largest timer frequency. Includes the fastest edge and a run of
        // overflows that gives a long period.
        write_timer_freq('1);
        add_evt(ACT_CAPTURE, '0);
        add_evt(ACT_CAPTURE, 16'd1);
        add_evt(ACT_CAPTURE, '0, 1'b1);
        for (int i = 0; i < 24; i++) begin
            add_evt(ACT_OVERFLOW, CAP_W'($urandom()));
        end
        add_evt(ACT_CAPTURE, '1);
        add_random_traffic(300);
        run_phase(0, 0);

        write_timer_freq(TF_W'(1));
        add_random_traffic(300);
        run_phase(81, 0);

        write_timer_freq(TF_W'($urandom_range(1, 16777215)));
        add_random_traffic(300);
        run_phase(0, 81);

        write_timer_freq(TF_W'($urandom_range(1, 16777215)));
        add_random_traffic(300);
        run_phase(14, 14);

        // A zero register still flags positive periods valid but gives no frequency.
        write_timer_freq('0);
        add_random_traffic(100);
        run_phase(0, 0);

        $display("Run covered %0d timer events and %0d measurements (%0d invalid periods)",
                 evts_taken, meas_seen, meas_invalid);
        $display("across %0d timer frequency settings and four idling mixes; %0d mismatches",
                 tf_settings + 1, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
